/* design/bcc_pkg.sv */
`default_nettype none

package bcc_pkg;

   localparam int BCC_COORD_BITS       = 16;
   localparam int BCC_WEIGHT_BITS      = 16;
   localparam int BCC_WEIGHT_FRAC_BITS = 14;

   typedef struct packed {
      logic signed [BCC_COORD_BITS-1:0] point_x;
      logic signed [BCC_COORD_BITS-1:0] point_y;
      logic signed [BCC_COORD_BITS-1:0] point_z;
      logic signed [BCC_COORD_BITS-1:0] vertex_a_x;
      logic signed [BCC_COORD_BITS-1:0] vertex_a_y;
      logic signed [BCC_COORD_BITS-1:0] vertex_a_z;
      logic signed [BCC_COORD_BITS-1:0] vertex_b_x;
      logic signed [BCC_COORD_BITS-1:0] vertex_b_y;
      logic signed [BCC_COORD_BITS-1:0] vertex_b_z;
      logic signed [BCC_COORD_BITS-1:0] vertex_c_x;
      logic signed [BCC_COORD_BITS-1:0] vertex_c_y;
      logic signed [BCC_COORD_BITS-1:0] vertex_c_z;
   } bcc_req_type;

   typedef struct packed {
      logic signed [BCC_WEIGHT_BITS-1:0] weight_u;
      logic signed [BCC_WEIGHT_BITS-1:0] weight_v;
      logic signed [BCC_WEIGHT_BITS-1:0] weight_w;
      logic                              degenerate;
      logic                              saturated;
   } bcc_rsp_type;

   typedef struct packed {
      logic degen;
      logic neg_v;
      logic neg_w;
   } bcc_tag_type;

endpackage

`default_nettype wire

/* design/bcc_divider.sv */
`default_nettype none

module bcc_divider import bcc_pkg::*; #(
   parameter int NW = 4 * (BCC_COORD_BITS + 2) + BCC_WEIGHT_FRAC_BITS + 2,
   parameter int RW = 4 * (BCC_COORD_BITS + 2)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] in_num_v,
   input  wire logic [NW-1:0] in_num_w,
   input  wire logic [RW-1:0] in_den,
   input  wire bcc_tag_type   in_tag,
   output logic               out_valid,
   output logic [NW-1:0]      out_quo_v,
   output logic [NW-1:0]      out_quo_w,
   output bcc_tag_type        out_tag
);

   logic              val_ff   [NW];
   logic [RW-1:0]     rem_v_ff [NW];
   logic [RW-1:0]     rem_w_ff [NW];
   logic [NW-1:0]     num_v_ff [NW];
   logic [NW-1:0]     num_w_ff [NW];
   logic [NW-1:0]     quo_v_ff [NW];
   logic [NW-1:0]     quo_w_ff [NW];
   logic [RW-1:0]     den_ff   [NW];
   bcc_tag_type       tag_ff   [NW];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic          val_src;
      logic [RW-1:0] rem_v_src, rem_w_src, den_src;
      logic [NW-1:0] num_v_src, num_w_src, quo_v_src, quo_w_src;
      bcc_tag_type   tag_src;
      logic [RW:0]   try_v, try_w, dif_v, dif_w;
      logic          ge_v, ge_w;
      logic [RW-1:0] rem_v_in, rem_w_in;

      if (s == 0) begin : g_first
         assign val_src   = in_valid;
         assign rem_v_src = '0;
         assign rem_w_src = '0;
         assign num_v_src = in_num_v;
         assign num_w_src = in_num_w;
         assign quo_v_src = '0;
         assign quo_w_src = '0;
         assign den_src   = in_den;
         assign tag_src   = in_tag;
      end else begin : g_next
         assign val_src   = val_ff[s-1];
         assign rem_v_src = rem_v_ff[s-1];
         assign rem_w_src = rem_w_ff[s-1];
         assign num_v_src = num_v_ff[s-1];
         assign num_w_src = num_w_ff[s-1];
         assign quo_v_src = quo_v_ff[s-1];
         assign quo_w_src = quo_w_ff[s-1];
         assign den_src   = den_ff[s-1];
         assign tag_src   = tag_ff[s-1];
      end

      always_comb begin
         try_v    = {rem_v_src, num_v_src[NW-1]};
         try_w    = {rem_w_src, num_w_src[NW-1]};
         dif_v    = try_v - {1'b0, den_src};
         dif_w    = try_w - {1'b0, den_src};
         ge_v     = (try_v >= {1'b0, den_src});
         ge_w     = (try_w >= {1'b0, den_src});
         rem_v_in = ge_v ? dif_v[RW-1:0] : try_v[RW-1:0];
         rem_w_in = ge_w ? dif_w[RW-1:0] : try_w[RW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[s] <= 1'b0;
         end else if (advance) begin
            val_ff[s] <= val_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_v_ff[s] <= rem_v_in;
            rem_w_ff[s] <= rem_w_in;
            num_v_ff[s] <= {num_v_src[NW-2:0], 1'b0};
            num_w_ff[s] <= {num_w_src[NW-2:0], 1'b0};
            quo_v_ff[s] <= {quo_v_src[NW-2:0], ge_v};
            quo_w_ff[s] <= {quo_w_src[NW-2:0], ge_w};
            den_ff[s]   <= den_src;
            tag_ff[s]   <= tag_src;
         end
      end
   end

   assign out_valid = val_ff[NW-1];
   assign out_quo_v = quo_v_ff[NW-1];
   assign out_quo_w = quo_w_ff[NW-1];
   assign out_tag   = tag_ff[NW-1];

endmodule

`default_nettype wire

/* design/triangle_barycentric_coords.sv */
// Channel  | Direction | Handshake             | Payload
// request  | in        | req_valid, req_stall  | req_data (bcc_req_type)
// response | out       | rsp_valid, rsp_stall  | rsp_data (bcc_rsp_type)
//
// One request enters per cycle while the response side is not stalled.
// The divider is a restoring divider, one quotient bit per stage over NW stages.
// Reset is synchronous and clears only the valid bits of the pipeline.
// A stalled response freezes the whole pipeline and stalls the request side.
`default_nettype none

module triangle_barycentric_coords import bcc_pkg::*; #(
   parameter int WEIGHT_FRAC_BITS = BCC_WEIGHT_FRAC_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire bcc_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output bcc_rsp_type      rsp_data
);

   localparam int C   = BCC_COORD_BITS;
   localparam int F   = WEIGHT_FRAC_BITS;
   localparam int EW  = C + 1;
   localparam int PE  = 2 * EW;
   localparam int DW  = 2 * EW + 2;
   localparam int H   = DW / 2;
   localparam int LW  = DW + H + 1;
   localparam int HW  = DW + (DW - H);
   localparam int PW  = 2 * DW;
   localparam int NW  = PW + F + 2;
   localparam int RW  = PW;
   localparam int XW  = NW + 3;
   localparam int OW  = BCC_WEIGHT_BITS;
   localparam int SW  = 34;

   localparam int PA [6] = '{0, 1, 2, 1, 0, 1};
   localparam int PB [6] = '{2, 1, 3, 4, 4, 3};

   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   logic signed [C-1:0] pt [3];
   logic signed [C-1:0] va [3];
   logic signed [C-1:0] vb [3];
   logic signed [C-1:0] vc [3];

   always_comb begin
      pt[0] = req_data.point_x;    pt[1] = req_data.point_y;    pt[2] = req_data.point_z;
      va[0] = req_data.vertex_a_x; va[1] = req_data.vertex_a_y; va[2] = req_data.vertex_a_z;
      vb[0] = req_data.vertex_b_x; vb[1] = req_data.vertex_b_y; vb[2] = req_data.vertex_b_z;
      vc[0] = req_data.vertex_c_x; vc[1] = req_data.vertex_c_y; vc[2] = req_data.vertex_c_z;
   end

   logic [7:1] val_ff;

   logic signed [EW-1:0] e_ff    [3][3];
   logic signed [PE-1:0] prod_ff [5][3];
   logic signed [DW-1:0] dot_ff  [5];
   logic signed [LW-1:0] lo_ff   [6];
   logic signed [HW-1:0] hi_ff   [6];
   logic signed [PW-1:0] mul_ff  [6];
   logic signed [PW:0]   denom_ff, vn_ff, wn_ff;
   logic [NW-1:0]        num_v_ff, num_w_ff;
   logic [RW-1:0]        den_ff;
   bcc_tag_type          tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (advance) begin
         val_ff <= {val_ff[6:1], req_valid};
      end
   end

   logic signed [PW:0] vn_abs, wn_abs;

   always_comb begin
      vn_abs = vn_ff[PW] ? -vn_ff : vn_ff;
      wn_abs = wn_ff[PW] ? -wn_ff : wn_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            e_ff[0][i] <= EW'(vb[i]) - EW'(va[i]);
            e_ff[1][i] <= EW'(vc[i]) - EW'(va[i]);
            e_ff[2][i] <= EW'(pt[i]) - EW'(va[i]);
         end
         for (int i = 0; i < 3; i++) begin
            prod_ff[0][i] <= PE'(e_ff[0][i]) * PE'(e_ff[0][i]);
            prod_ff[1][i] <= PE'(e_ff[0][i]) * PE'(e_ff[1][i]);
            prod_ff[2][i] <= PE'(e_ff[1][i]) * PE'(e_ff[1][i]);
            prod_ff[3][i] <= PE'(e_ff[2][i]) * PE'(e_ff[0][i]);
            prod_ff[4][i] <= PE'(e_ff[2][i]) * PE'(e_ff[1][i]);
         end
         for (int k = 0; k < 5; k++) begin
            dot_ff[k] <= DW'(prod_ff[k][0]) + DW'(prod_ff[k][1]) + DW'(prod_ff[k][2]);
         end
         for (int k = 0; k < 6; k++) begin
            lo_ff[k] <= LW'(dot_ff[PA[k]]) * LW'($signed({1'b0, dot_ff[PB[k]][H-1:0]}));
            hi_ff[k] <= HW'(dot_ff[PA[k]]) * HW'($signed(dot_ff[PB[k]][DW-1:H]));
         end
         for (int k = 0; k < 6; k++) begin
            mul_ff[k] <= (PW'(hi_ff[k]) <<< H) + PW'(lo_ff[k]);
         end
         denom_ff <= (PW+1)'(mul_ff[0]) - (PW+1)'(mul_ff[1]);
         vn_ff    <= (PW+1)'(mul_ff[2]) - (PW+1)'(mul_ff[3]);
         wn_ff    <= (PW+1)'(mul_ff[4]) - (PW+1)'(mul_ff[5]);
         tag_ff.degen <= (denom_ff == '0) || denom_ff[PW];
         tag_ff.neg_v <= vn_ff[PW];
         tag_ff.neg_w <= wn_ff[PW];
         num_v_ff <= (NW'(vn_abs[PW-1:0]) << (F + 1)) + NW'(denom_ff[PW-1:0]);
         num_w_ff <= (NW'(wn_abs[PW-1:0]) << (F + 1)) + NW'(denom_ff[PW-1:0]);
         den_ff   <= {denom_ff[PW-2:0], 1'b0};
      end
   end

   logic          div_valid;
   logic [NW-1:0] quo_v, quo_w;
   bcc_tag_type   div_tag;

   bcc_divider #(
      .NW (NW),
      .RW (RW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (val_ff[7]),
      .in_num_v  (num_v_ff),
      .in_num_w  (num_w_ff),
      .in_den    (den_ff),
      .in_tag    (tag_ff),
      .out_valid (div_valid),
      .out_quo_v (quo_v),
      .out_quo_w (quo_w),
      .out_tag   (div_tag)
   );

   function automatic logic [OW:0] clip(input logic signed [XW-1:0] x);
      logic hi_ones, hi_zeros;
      hi_ones  = &x[XW-1:OW-1];
      hi_zeros = ~|x[XW-1:OW-1];
      if (hi_ones || hi_zeros) begin
         return {1'b0, x[OW-1:0]};
      end else if (x[XW-1]) begin
         return {1'b1, 1'b1, {(OW-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(OW-1){1'b1}}};
      end
   endfunction

   logic signed [XW-1:0] v_full, w_full, u_full;
   logic [OW:0]          u_c, v_c, w_c;
   bcc_rsp_type          rsp_in;
   bcc_rsp_type          rsp_ff;
   logic                 rsp_valid_ff;

   always_comb begin
      v_full = div_tag.neg_v ? -XW'({1'b0, quo_v}) : XW'({1'b0, quo_v});
      w_full = div_tag.neg_w ? -XW'({1'b0, quo_w}) : XW'({1'b0, quo_w});
      u_full = (XW'(1) <<< F) - v_full - w_full;
      u_c    = clip(u_full);
      v_c    = clip(v_full);
      w_c    = clip(w_full);
      if (div_tag.degen) begin
         rsp_in = '0;
         rsp_in.degenerate = 1'b1;
      end else begin
         rsp_in.weight_u   = u_c[OW-1:0];
         rsp_in.weight_v   = v_c[OW-1:0];
         rsp_in.weight_w   = w_c[OW-1:0];
         rsp_in.degenerate = 1'b0;
         rsp_in.saturated  = u_c[OW] | v_c[OW] | w_c[OW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.weight_u == '0 && rsp_data.weight_v == '0 &&
         rsp_data.weight_w == '0 && !rsp_data.saturated)
      else $error("degenerate response carries nonzero weights");

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate && !rsp_data.saturated |->
         SW'(rsp_data.weight_u) + SW'(rsp_data.weight_v) + SW'(rsp_data.weight_w)
            == (SW'(1) <<< F))
      else $error("unclipped weights do not sum to one");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

/* bench/bcc_checker.sv */
`default_nettype none

module bcc_checker import bcc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire bcc_req_type req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire bcc_rsp_type rsp_data,
   output int               mismatches,
   output int               weights_pending
);

   typedef logic signed [127:0] wide_type;

   bcc_rsp_type weights_due[$];

   function automatic wide_type round_quotient(input wide_type num, input wide_type den);
      logic        neg;
      logic [127:0] mag;
      logic [127:0] quo;
      neg = num < 0;
      mag = neg ? -num : num;
      mag = (mag << (BCC_WEIGHT_FRAC_BITS + 1)) + den;
      quo = mag / (den << 1);
      return neg ? -$signed(quo) : $signed(quo);
   endfunction

   function automatic logic [15:0] clip_weight(input wide_type x, inout logic sat);
      if (x > 32767) begin
         sat = 1'b1;
         return 16'h7fff;
      end
      if (x < -32768) begin
         sat = 1'b1;
         return 16'h8000;
      end
      return x[15:0];
   endfunction

   function automatic bcc_rsp_type barycentric_weights(input bcc_req_type r);
      wide_type    p[3], a[3], b[3], c[3], e0[3], e1[3], e2[3];
      wide_type    d00, d01, d11, d20, d21, den, v, w, u;
      logic        sat;
      bcc_rsp_type res;
      p[0] = $signed(r.point_x);    p[1] = $signed(r.point_y);    p[2] = $signed(r.point_z);
      a[0] = $signed(r.vertex_a_x); a[1] = $signed(r.vertex_a_y); a[2] = $signed(r.vertex_a_z);
      b[0] = $signed(r.vertex_b_x); b[1] = $signed(r.vertex_b_y); b[2] = $signed(r.vertex_b_z);
      c[0] = $signed(r.vertex_c_x); c[1] = $signed(r.vertex_c_y); c[2] = $signed(r.vertex_c_z);
      for (int k = 0; k < 3; k++) begin
         e0[k] = b[k] - a[k];
         e1[k] = c[k] - a[k];
         e2[k] = p[k] - a[k];
      end
      d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
      d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
      d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
      d20 = e2[0]*e0[0] + e2[1]*e0[1] + e2[2]*e0[2];
      d21 = e2[0]*e1[0] + e2[1]*e1[1] + e2[2]*e1[2];
      den = d00*d11 - d01*d01;
      res = '0;
      if (den <= 0) begin
         res.degenerate = 1'b1;
         return res;
      end
      v = round_quotient(d11*d20 - d01*d21, den);
      w = round_quotient(d00*d21 - d01*d20, den);
      u = (wide_type'(1) <<< BCC_WEIGHT_FRAC_BITS) - v - w;
      sat = 1'b0;
      res.weight_u = clip_weight(u, sat);
      res.weight_v = clip_weight(v, sat);
      res.weight_w = clip_weight(w, sat);
      res.saturated = sat;
      return res;
   endfunction

   always @(posedge clock) begin
      bcc_rsp_type want;
      if (reset) begin
         mismatches <= 0;
      end else begin
         if (req_valid && !req_stall)
            weights_due = {weights_due, barycentric_weights(req_data)};
         if (rsp_valid && !rsp_stall) begin
            if (weights_due.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected response %h", rsp_data);
            end else begin
               want = weights_due.pop_front();
               if (rsp_data.weight_u !== want.weight_u || rsp_data.weight_v !== want.weight_v
                   || rsp_data.weight_w !== want.weight_w
                   || rsp_data.degenerate !== want.degenerate
                   || rsp_data.saturated !== want.saturated) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("expected u=%h v=%h w=%h degen=%b sat=%b,",
                              want.weight_u, want.weight_v, want.weight_w, want.degenerate,
                              want.saturated,
                              " got u=%h v=%h w=%h degen=%b sat=%b",
                              rsp_data.weight_u, rsp_data.weight_v,
                              rsp_data.weight_w, rsp_data.degenerate, rsp_data.saturated);
               end
            end
         end
      end
      weights_pending <= weights_due.size();
   end

endmodule

`default_nettype wire

/* bench/tb_triangle_barycentric_coords.sv */
`default_nettype none

module tb_triangle_barycentric_coords import bcc_pkg::*;;

   localparam int CYCLE_LIMIT = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   bcc_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   bcc_rsp_type rsp_data;
   logic        calm = 1'b0;
   int          mismatches;
   int          weights_pending;
   int          cycles = 0;

   triangle_barycentric_coords uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   bcc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .mismatches(mismatches), .weights_pending(weights_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 27);
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("triangle_barycentric_coords: mismatch");
         $finish;
      end
   end

   function automatic bcc_req_type make_request(input int px, py, pz, ax, ay, az,
                                                 input int bx, by, bz, cx, cy, cz);
      bcc_req_type r;
      r.point_x    = BCC_COORD_BITS'(px);
      r.point_y    = BCC_COORD_BITS'(py);
      r.point_z    = BCC_COORD_BITS'(pz);
      r.vertex_a_x = BCC_COORD_BITS'(ax);
      r.vertex_a_y = BCC_COORD_BITS'(ay);
      r.vertex_a_z = BCC_COORD_BITS'(az);
      r.vertex_b_x = BCC_COORD_BITS'(bx);
      r.vertex_b_y = BCC_COORD_BITS'(by);
      r.vertex_b_z = BCC_COORD_BITS'(bz);
      r.vertex_c_x = BCC_COORD_BITS'(cx);
      r.vertex_c_y = BCC_COORD_BITS'(cy);
      r.vertex_c_z = BCC_COORD_BITS'(cz);
      return r;
   endfunction

   function automatic int near(input int base, input int span);
      return base + $signed($urandom_range(2 * span)) - span;
   endfunction

   function automatic bcc_req_type random_request();
      bcc_req_type r;
      int          ox, oy, oz, span, k;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      ox = $signed(r.vertex_a_x) / 2;
      oy = $signed(r.vertex_a_y) / 2;
      oz = $signed(r.vertex_a_z) / 2;
      span = 1 << $urandom_range(12, 1);
      case ($urandom_range(9))
         0, 1: ;
         2: begin
            r.vertex_b_x = r.vertex_a_x; r.vertex_b_y = r.vertex_a_y;
            r.vertex_b_z = r.vertex_a_z;
         end
         3: begin
            k = $urandom_range(3);
            r = make_request(near(ox, span), near(oy, span), near(oz, span), ox, oy, oz,
                             near(ox, span), near(oy, span), near(oz, span), 0, 0, 0);
            r.vertex_c_x = BCC_COORD_BITS'(ox + k * ($signed(r.vertex_b_x) - ox));
            r.vertex_c_y = BCC_COORD_BITS'(oy + k * ($signed(r.vertex_b_y) - oy));
            r.vertex_c_z = BCC_COORD_BITS'(oz + k * ($signed(r.vertex_b_z) - oz));
         end
         default:
            r = make_request(near(ox, span), near(oy, span), near(oz, span),
                             near(ox, span), near(oy, span), near(oz, span),
                             near(ox, span), near(oy, span), near(oz, span),
                             near(ox, span), near(oy, span), near(oz, span));
      endcase
      return r;
   endfunction

   task automatic send_request(input bcc_req_type r);
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      bcc_req_type directed[$];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = {directed, make_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      directed = {directed, make_request(0, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0)};
      directed = {directed, make_request(256, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0)};
      directed = {directed, make_request(0, 256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0)};
      directed = {directed, make_request(85, 85, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0)};
      directed = {directed, make_request(128, 128, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0)};
      directed = {directed, make_request(32767, 32767, 32767, 0, 0, 0, 1, 0, 0, 0, 1, 0)};
      directed = {directed, make_request(-32768, -32768, -32768, 0, 0, 0, 1, 0, 0, 0, 1, 0)};
      directed = {directed, make_request(0, 0, 0, -32768, -32768, -32768,
                                         32767, -32768, -32768, -32768, 32767, 32767)};
      directed = {directed, make_request(32767, 32767, 32767, 32767, 32767, 32767,
                                         -32768, -32768, -32768, -32768, 32767, -32768)};
      directed = {directed, make_request(-32768, 32767, -32768, 32767, -32768, 32767,
                                         -32768, -32768, 32767, 32767, 32767, -32768)};
      directed = {directed, make_request(5, 5, 5, 1, 1, 1, 2, 2, 2, 4, 4, 4)};
      directed = {directed, make_request(100, -7, 3, 0, 0, 0, 3, 0, 0, 0, 0, 0)};
      directed = {directed, make_request(1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 3, 0)};
      directed = {directed, make_request(-256, 512, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0)};
      directed = {directed, make_request(1, 0, 0, 0, 0, 0, 3, 0, 0, 0, 3, 0)};
      directed = {directed, make_request(-1, 2, 0, 0, 0, 0, 3, 0, 0, 0, 3, 0)};
      directed = {directed, make_request(-32768, 0, 0, 0, 0, 0, 2, 0, 0, 0, 2, 0)};
      directed = {directed, make_request(32767, -32768, 0, 0, 0, 0, 2, 0, 0, 0, 2, 0)};
      directed = {directed, make_request(0, 0, 32767, 0, 0, 0, 256, 0, 0, 0, 256, 0)};
      foreach (directed[i]) send_request(directed[i]);

      for (int n = 0; n < 1000; n++) begin
         calm <= (n >= 400 && n < 550);
         send_request(random_request());
      end
      req_valid <= 1'b0;
      calm <= 1'b0;

      while (weights_pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (mismatches == 0 && weights_pending == 0)
         $display("triangle_barycentric_coords: match");
      else
         $display("triangle_barycentric_coords: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
